// ===== rtl/core/neumaier_compensated_sum_unit_macros.svh =====
// Assertion macros for the compensated sum unit.
`ifndef NEUMAIER_COMPENSATED_SUM_UNIT_MACROS_SVH
`define NEUMAIER_COMPENSATED_SUM_UNIT_MACROS_SVH

// Flag a condition that must never hold outside reset.
`define NSUM_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// Flag a broken implication outside reset.
`define NSUM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/core/nsum_pkg.sv =====
// Shared types and constants of the compensated sum unit.
`default_nettype none
package nsum_pkg;
  localparam int unsigned FpW = 64;
  localparam int unsigned ExpW = 11;
  localparam int unsigned FracW = 52;
  localparam int unsigned ManW = FracW + 1;
  localparam int unsigned ExtW = ManW + 3;
  localparam int unsigned FaddLat = 4;
  localparam int unsigned QDepth = 2;
  localparam logic [ExpW-1:0] ExpMax = '1;
  localparam logic [FpW-1:0] DefaultNan = 64'hFFF8_0000_0000_0000;

  typedef struct packed {
    logic [FpW-1:0] value;
    logic           last;
  } q_item_t;

  typedef struct packed {
    logic [1:0] count;
  } front_stat_t;

  typedef struct packed {
    logic fa_issue;
    logic fa_done;
  } back_stat_t;
endpackage
`default_nettype wire

// ===== rtl/core/nsum_fadd.sv =====
// Four-stage pipelined binary64 adder with round-to-nearest-even.
`default_nettype none
module nsum_fadd (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  input  wire logic [nsum_pkg::FpW-1:0]  a,
  input  wire logic [nsum_pkg::FpW-1:0]  b,
  input  wire logic                      sub,
  output logic                           out_valid,
  output logic [nsum_pkg::FpW-1:0]       res
);
  localparam int unsigned EW = nsum_pkg::ExpW;
  localparam int unsigned MW = nsum_pkg::ManW;
  localparam int unsigned XW = nsum_pkg::ExtW;

  function automatic logic [5:0] lzc(input logic [XW-1:0] v);
    logic [5:0] n;
    n = 6'(XW);
    for (int i = 0; i < XW; i++) begin
      if (v[i]) n = 6'(XW - 1 - i);
    end
    return n;
  endfunction

  logic [nsum_pkg::FaddLat-1:0] vld;

  // stage 1
  logic a_nan, b_nan, a_inf, b_inf, bs, swap;
  logic [nsum_pkg::FpW-1:0] bn, big, sml, spec_val_next;
  logic spec_next;
  logic s1_spec, s1_sign, s1_esub;
  logic [nsum_pkg::FpW-1:0] s1_spec_val;
  logic [EW-1:0] s1_exp_l, s1_exp_s;
  logic [MW-1:0] s1_man_l, s1_man_s;

  always_comb begin
    a_nan = (a[62:52] == nsum_pkg::ExpMax) && (a[51:0] != '0);
    b_nan = (b[62:52] == nsum_pkg::ExpMax) && (b[51:0] != '0);
    a_inf = (a[62:52] == nsum_pkg::ExpMax) && (a[51:0] == '0);
    b_inf = (b[62:52] == nsum_pkg::ExpMax) && (b[51:0] == '0);
    bs = b[63] ^ (sub & ~b_nan);
    bn = {bs, b[62:0]};
    swap = b[62:0] > a[62:0];
    big = swap ? bn : a;
    sml = swap ? a : bn;
    spec_next = 1'b1;
    if (a_nan) spec_val_next = {a[63], nsum_pkg::ExpMax, 1'b1, a[50:0]};
    else if (b_nan) spec_val_next = {b[63], nsum_pkg::ExpMax, 1'b1, b[50:0]};
    else if (a_inf && b_inf && (a[63] != bs)) spec_val_next = nsum_pkg::DefaultNan;
    else if (a_inf) spec_val_next = a;
    else if (b_inf) spec_val_next = bn;
    else begin
      spec_next = 1'b0;
      spec_val_next = a;
    end
  end

  always_ff @(posedge clk) begin
    s1_spec <= spec_next;
    s1_spec_val <= spec_val_next;
    s1_sign <= big[63];
    s1_esub <= big[63] ^ sml[63];
    s1_exp_l <= (big[62:52] == '0) ? EW'(1) : big[62:52];
    s1_exp_s <= (sml[62:52] == '0) ? EW'(1) : sml[62:52];
    s1_man_l <= {big[62:52] != '0, big[51:0]};
    s1_man_s <= {sml[62:52] != '0, sml[51:0]};
  end

  // stage 2
  logic [EW-1:0] dif;
  logic [XW-1:0] ms_ext, shifted, mask, aligned;
  logic [XW:0] sum_next;
  always_comb begin
    dif = s1_exp_l - s1_exp_s;
    ms_ext = {s1_man_s, 3'b000};
    shifted = ms_ext >> dif[5:0];
    mask = (XW'(1) << dif[5:0]) - XW'(1);
    if (dif >= EW'(XW)) aligned = {{(XW-1){1'b0}}, |s1_man_s};
    else aligned = {shifted[XW-1:1], shifted[0] | (|(ms_ext & mask))};
    if (s1_esub) sum_next = {1'b0, s1_man_l, 3'b000} - {1'b0, aligned};
    else sum_next = {1'b0, s1_man_l, 3'b000} + {1'b0, aligned};
  end

  logic s2_spec, s2_sign, s2_esub;
  logic [nsum_pkg::FpW-1:0] s2_spec_val;
  logic [EW-1:0] s2_exp;
  logic [XW:0] s2_sum;
  always_ff @(posedge clk) begin
    s2_spec <= s1_spec;
    s2_spec_val <= s1_spec_val;
    s2_sign <= s1_sign;
    s2_esub <= s1_esub;
    s2_exp <= s1_exp_l;
    s2_sum <= sum_next;
  end

  // stage 3
  logic [5:0] lz;
  logic [EW-1:0] maxsh, sh;
  logic [XW-1:0] nm;
  logic [EW:0] ne;
  logic zero_next, zsign;
  always_comb begin
    lz = lzc(s2_sum[XW-1:0]);
    maxsh = s2_exp - EW'(1);
    sh = (EW'(lz) < maxsh) ? EW'(lz) : maxsh;
    zero_next = s2_sum == '0;
    zsign = s2_esub ? 1'b0 : s2_sign;
    if (s2_sum[XW]) begin
      nm = {s2_sum[XW:2], s2_sum[1] | s2_sum[0]};
      ne = {1'b0, s2_exp} + (EW+1)'(1);
    end else begin
      nm = s2_sum[XW-1:0] << sh[5:0];
      ne = {1'b0, s2_exp} - {1'b0, sh};
    end
  end

  logic s3_spec, s3_sign, s3_zero;
  logic [nsum_pkg::FpW-1:0] s3_spec_val;
  logic [EW:0] s3_exp;
  logic [XW-1:0] s3_man;
  always_ff @(posedge clk) begin
    s3_spec <= s2_spec;
    s3_spec_val <= s2_spec_val;
    s3_sign <= zero_next ? zsign : s2_sign;
    s3_zero <= zero_next;
    s3_exp <= ne;
    s3_man <= nm;
  end

  // stage 4
  logic up;
  logic [MW:0] mr;
  logic [MW-1:0] mant;
  logic [EW:0] fe;
  logic [nsum_pkg::FpW-1:0] res_next;
  always_comb begin
    up = s3_man[2] & (s3_man[1] | s3_man[0] | s3_man[3]);
    mr = {1'b0, s3_man[XW-1:3]} + (MW+1)'(up);
    if (mr[MW]) begin
      mant = mr[MW:1];
      fe = s3_exp + (EW+1)'(1);
    end else begin
      mant = mr[MW-1:0];
      fe = s3_exp;
    end
    if (s3_spec) res_next = s3_spec_val;
    else if (s3_zero) res_next = {s3_sign, 63'b0};
    else if (fe >= {1'b0, nsum_pkg::ExpMax}) res_next = {s3_sign, nsum_pkg::ExpMax, 52'b0};
    else res_next = {s3_sign, mant[MW-1] ? fe[EW-1:0] : EW'(0), mant[MW-2:0]};
  end

  always_ff @(posedge clk) begin
    res <= res_next;
    if (rst) vld <= '0;
    else vld <= {vld[nsum_pkg::FaddLat-2:0], in_valid};
  end

  assign out_valid = vld[nsum_pkg::FaddLat-1];
endmodule
`default_nettype wire

// ===== rtl/core/nsum_front.sv =====
// Input stage: accepts addends into a two-entry queue.
`default_nettype none
module nsum_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [63:0]          s_tdata,
  input  wire logic                 s_tlast,
  output logic                      q_valid,
  output nsum_pkg::q_item_t         q_item,
  input  wire logic                 q_pop,
  output nsum_pkg::front_stat_t     stat
);
  nsum_pkg::q_item_t mem [nsum_pkg::QDepth];
  logic rd_ptr, wr_ptr;
  logic [1:0] count;
  logic push, pop;

  assign s_tready = count != 2'(nsum_pkg::QDepth);
  assign push = s_tvalid && s_tready;
  assign q_valid = count != '0;
  assign pop = q_pop && q_valid;
  assign q_item = mem[rd_ptr];
  assign stat.count = count;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= '{value: s_tdata, last: s_tlast};
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/nsum_back.sv =====
// Sequencer that runs the compensated update on a shared adder.
`default_nettype none
module nsum_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 q_valid,
  input  wire nsum_pkg::q_item_t    q_item,
  output logic                      q_pop,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [63:0]               m_tdata,
  output nsum_pkg::back_stat_t      stat
);
  typedef enum logic [2:0] {
    ST_IDLE, ST_T, ST_A, ST_B, ST_E, ST_F, ST_OUT
  } state_t;

  state_t state;
  logic busy, ge, last;
  logic [63:0] s, e, v, t, x;
  logic fa_in_valid, fa_out_valid, fa_sub;
  logic [63:0] fa_a, fa_b, fa_res;
  logic s_nan, v_nan, ge_next;

  nsum_fadd u_fadd (
    .clk(clk), .rst(rst), .in_valid(fa_in_valid), .a(fa_a), .b(fa_b),
    .sub(fa_sub), .out_valid(fa_out_valid), .res(fa_res)
  );

  always_comb begin
    s_nan = (s[62:52] == nsum_pkg::ExpMax) && (s[51:0] != '0);
    v_nan = (q_item.value[62:52] == nsum_pkg::ExpMax) && (q_item.value[51:0] != '0);
    ge_next = !s_nan && !v_nan && (s[62:0] >= q_item.value[62:0]);
    q_pop = (state == ST_IDLE) && q_valid;
    fa_in_valid = !busy && (state != ST_IDLE) && (state != ST_OUT);
    fa_sub = 1'b0;
    fa_a = s;
    fa_b = v;
    unique case (state)
      ST_T: begin
        fa_a = s;
        fa_b = v;
      end
      ST_A: begin
        fa_a = ge ? s : v;
        fa_b = t;
        fa_sub = 1'b1;
      end
      ST_B: begin
        fa_a = x;
        fa_b = ge ? v : s;
      end
      ST_E: begin
        fa_a = e;
        fa_b = x;
      end
      ST_F: begin
        fa_a = t;
        fa_b = e;
      end
      default: begin
        fa_a = s;
        fa_b = v;
      end
    endcase
  end

  assign stat.fa_issue = fa_in_valid;
  assign stat.fa_done = fa_out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy <= 1'b0;
      m_tvalid <= 1'b0;
      s <= '0;
      e <= '0;
    end else begin
      if (m_tvalid && m_tready && (state != ST_OUT)) m_tvalid <= 1'b0;
      if (fa_in_valid) busy <= 1'b1;
      if (fa_out_valid) busy <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            v <= q_item.value;
            last <= q_item.last;
            ge <= ge_next;
            state <= ST_T;
          end
        end
        ST_T: begin
          if (fa_out_valid) begin
            t <= fa_res;
            state <= ST_A;
          end
        end
        ST_A: begin
          if (fa_out_valid) begin
            x <= fa_res;
            state <= ST_B;
          end
        end
        ST_B: begin
          if (fa_out_valid) begin
            x <= fa_res;
            state <= ST_E;
          end
        end
        ST_E: begin
          if (fa_out_valid) begin
            e <= fa_res;
            s <= t;
            state <= last ? ST_F : ST_IDLE;
          end
        end
        ST_F: begin
          if (fa_out_valid) begin
            t <= fa_res;
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata <= t;
            m_tvalid <= 1'b1;
            s <= '0;
            e <= '0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/neumaier_compensated_sum_unit.sv =====
// Top level of the Neumaier compensated binary64 sum unit.
// Sums a stream of binary64 addends with Neumaier compensation and emits
// sum plus error on the addend flagged by tlast, then starts a fresh sum at +0.
// Each addend takes four dependent adds on one four-stage adder; a last
// addend adds one more add and the output load.
// A two-entry input queue and the output register let either side stall.
`default_nettype none
`include "neumaier_compensated_sum_unit_macros.svh"
module neumaier_compensated_sum_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // value_bits[63:0]
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata    // total_bits[63:0]
);
  logic q_valid, q_pop;
  nsum_pkg::q_item_t q_item;
  nsum_pkg::front_stat_t front_stat;
  nsum_pkg::back_stat_t back_stat;

  nsum_front u_front (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .s_tlast(s_tlast), .q_valid(q_valid),
    .q_item(q_item), .q_pop(q_pop), .stat(front_stat)
  );

  nsum_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .stat(back_stat)
  );

  `NSUM_ASSERT_NEVER(a_q_over, clk, rst, front_stat.count > 2'(nsum_pkg::QDepth), "queue overflow")
  `NSUM_ASSERT_IMPLY(a_fa_lat, clk, rst, back_stat.fa_done, $past(back_stat.fa_issue, 4), "adder result without issue")
  `NSUM_ASSERT_IMPLY(a_fa_one, clk, rst, back_stat.fa_issue, !back_stat.fa_done, "issue while result returns")
endmodule
`default_nettype wire
